@@ rtl/assert_macros.svh @@
// Assertion macros shared by the score ordered table modules.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define SOT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define SOT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sot_pkg.sv @@
// Shared constants, codes and controller/datapath interface structs
// for the score ordered table. No dependencies.
package sot_pkg;

  localparam int CAPACITY    = 32;
  localparam int MAX_RESULTS = 32;

  localparam int FUNC_W   = 2;
  localparam int ID_W     = 32;
  localparam int SCORE_W  = 32;
  localparam int RC_W     = 6;
  localparam int STATUS_W = 2;

  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = (OCC_W > RC_W) ? OCC_W : RC_W;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd3;

  typedef struct packed {
    logic                insert_en;
    logic                remove_start;
    logic                remove_step;
    logic                read_start;
    logic                read_step;
    logic                out_load;
    logic                out_entry;
    logic                out_last;
    logic [STATUS_W-1:0] out_status;
  } sot_cmd_t;

  typedef struct packed {
    logic full;
    logic any_match;
    logic found;
    logic read_none;
    logic read_last;
    logic out_free;
  } sot_sts_t;

endpackage

@@ rtl/sot_datapath.sv @@
// Datapath of the score ordered table: sorted cell row, occupancy, read
// cursor and the result beat register. Depends on sot_pkg, assert_macros.svh.
module sot_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sot_pkg::ID_W-1:0]      in_entry_id,
  input  logic [sot_pkg::SCORE_W-1:0]   in_entry_score,
  input  logic [sot_pkg::RC_W-1:0]      in_read_count,
  input  sot_pkg::sot_cmd_t             cmd,
  output sot_pkg::sot_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sot_pkg::STATUS_W-1:0]  out_status,
  output logic [sot_pkg::ID_W-1:0]      out_id,
  output logic [sot_pkg::SCORE_W-1:0]   out_score,
  output logic                          out_last
);
  import sot_pkg::*;

  logic [ID_W-1:0]     id_q    [CAPACITY];
  logic [SCORE_W-1:0]  score_q [CAPACITY];
  logic [CAPACITY-1:0] in_use;
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] lt_below;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] pmatch;

  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic [ID_W-1:0]     rm_id_r;
  logic                found_r;
  logic [IDX_W-1:0]    idx_r;
  logic [CNT_W-1:0]    num_r;
  logic [CNT_W-1:0]    num_calc;
  logic                do_insert;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [SCORE_W-1:0]  out_score_r;
  logic                out_last_r;

  assign do_insert = cmd.insert_en && !sts.full;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      in_use[i] = OCC_W'(i) < occ_r;
      lt[i]     = in_use[i] && (score_q[i] < in_entry_score);
      match[i]  = in_use[i] && (id_q[i] == rm_id_r);
    end
    pmatch[0] = match[0];
    for (int i = 1; i < CAPACITY; i++) begin
      pmatch[i] = pmatch[i-1] | match[i];
    end
  end

  assign lt_below = {lt[CAPACITY-2:0], 1'b1};

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ID_W-1:0]    cid_r;
    logic [SCORE_W-1:0] cscore_r;
    logic [ID_W-1:0]    id_dn, id_up;
    logic [SCORE_W-1:0] score_dn, score_up;

    if (g == 0) begin : g_bot
      assign id_dn    = cid_r;
      assign score_dn = cscore_r;
    end else begin : g_mid
      assign id_dn    = id_q[g-1];
      assign score_dn = score_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_top
      assign id_up    = cid_r;
      assign score_up = cscore_r;
    end else begin : g_low
      assign id_up    = id_q[g+1];
      assign score_up = score_q[g+1];
    end

    always_ff @(posedge clk) begin
      if (do_insert && !lt[g]) begin
        cid_r    <= lt_below[g] ? in_entry_id : id_dn;
        cscore_r <= lt_below[g] ? in_entry_score : score_dn;
      end else if (cmd.remove_step && pmatch[g]) begin
        cid_r    <= id_up;
        cscore_r <= score_up;
      end
    end

    assign id_q[g]    = cid_r;
    assign score_q[g] = cscore_r;
  end

  always_comb begin
    num_calc = CNT_W'(in_read_count);
    if (CNT_W'(occ_r) < num_calc) begin
      num_calc = CNT_W'(occ_r);
    end
    if (CNT_W'(MAX_RESULTS) < num_calc) begin
      num_calc = CNT_W'(MAX_RESULTS);
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (do_insert) begin
      occ_nxt = occ_r + 1'b1;
    end else if (cmd.remove_step) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      found_r     <= 1'b0;
      idx_r       <= '0;
      num_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (cmd.remove_start) begin
        found_r <= 1'b0;
      end else if (cmd.remove_step) begin
        found_r <= 1'b1;
      end
      if (cmd.read_start) begin
        idx_r <= '0;
        num_r <= num_calc;
      end else if (cmd.read_step) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.remove_start) begin
      rm_id_r <= in_entry_id;
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_id_r     <= cmd.out_entry ? id_q[idx_r] : '0;
      out_score_r  <= cmd.out_entry ? score_q[idx_r] : '0;
      out_last_r   <= cmd.out_last;
    end
  end

  assign sts.full      = occ_r >= OCC_W'(CAPACITY);
  assign sts.any_match = pmatch[CAPACITY-1];
  assign sts.found     = found_r;
  assign sts.read_none = num_calc == '0;
  assign sts.read_last = (CNT_W'(idx_r) + 1'b1) == num_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;
  assign out_score  = out_score_r;
  assign out_last   = out_last_r;

`include "assert_macros.svh"

  `SOT_ASSERT(a_occ_bound, occ_r <= OCC_W'(CAPACITY), "occupancy above capacity")
  `SOT_ASSERT(a_ins_grow, do_insert |=> (occ_r == $past(occ_r) + 1'b1), "insert lost")
  `SOT_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid, "result beat valid after reset")

endmodule

@@ rtl/sot_ctrl.sv @@
// Controller of the score ordered table: sequences insert, remove and read
// and issues datapath commands. Depends on sot_pkg, assert_macros.svh.
module sot_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [sot_pkg::FUNC_W-1:0]  in_func,
  output logic                        in_stall,
  input  sot_pkg::sot_sts_t           sts,
  output sot_pkg::sot_cmd_t           cmd
);
  import sot_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REMOVE = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign in_stall = !((state_r == S_IDLE) && sts.out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FUNC_INSERT: begin
              cmd.insert_en  = 1'b1;
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.out_status = sts.full ? STS_FULL : STS_OK;
            end
            FUNC_REMOVE: begin
              cmd.remove_start = 1'b1;
              state_nxt        = S_REMOVE;
            end
            FUNC_READ: begin
              cmd.read_start = 1'b1;
              if (sts.read_none) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = STS_EMPTY;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_REMOVE: begin
        if (sts.any_match) begin
          cmd.remove_step = 1'b1;
        end else if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = sts.found ? STS_OK : STS_NOT_FOUND;
          state_nxt      = S_IDLE;
        end
      end
      S_READ: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_entry  = 1'b1;
          cmd.out_last   = sts.read_last;
          cmd.out_status = STS_OK;
          cmd.read_step  = 1'b1;
          if (sts.read_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`include "assert_macros.svh"

  `SOT_ASSERT(a_load_free, cmd.out_load |-> sts.out_free, "result beat overwritten")
  `SOT_ASSERT(a_read_ends, (state_r == S_READ && cmd.out_last) |=> (state_r == S_IDLE), "read did not end")

endmodule

@@ rtl/score_ordered_table_top.sv @@
// Score ordered table: up to CAPACITY (id, score) entries kept in ascending
// score order, with insert, remove by id and read of the lowest entries.
// Depends on sot_pkg, sot_ctrl, sot_datapath.
//
// Input channel in_*: one beat carries func, entry_id, entry_score and
// read_count. Result channel out_*: status, out_id, out_score, last; the
// final beat of each command has out_last set. func 3 gives no beat.
// An insert loads its beat into the result beat register when accepted. A
// remove first takes a step for each matching entry found, then loads its
// beat. A read first latches its count, then loads one entry per step,
// lowest score first; a read with nothing to give loads its beat on accept.
// Throughput: one command at a time; the next is taken once the controller
// is idle and the result beat is free, so an insert sustains one item every
// cycle while out_stall is low; a remove or read must finish first.
// Reset empties the table and drops any pending beat. While out_stall is
// high with a beat pending, it holds, no new beat loads and in_stall is high.
module score_ordered_table_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sot_pkg::FUNC_W-1:0]    in_func,
  input  logic [sot_pkg::ID_W-1:0]      in_entry_id,
  input  logic [sot_pkg::SCORE_W-1:0]   in_entry_score,
  input  logic [sot_pkg::RC_W-1:0]      in_read_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sot_pkg::STATUS_W-1:0]  out_status,
  output logic [sot_pkg::ID_W-1:0]      out_id,
  output logic [sot_pkg::SCORE_W-1:0]   out_score,
  output logic                          out_last
);
  import sot_pkg::*;

  sot_cmd_t cmd;
  sot_sts_t sts;

  sot_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sot_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_entry_id    (in_entry_id),
    .in_entry_score (in_entry_score),
    .in_read_count  (in_read_count),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_id         (out_id),
    .out_score      (out_score),
    .out_last       (out_last)
  );

endmodule

@@ test/score_ordered_table_top_tb.sv @@
// Testbench for score_ordered_table_top: directed and random insert, remove and read
// commands checked beat by beat against a behavioral table kept in the bench.
// Depends on sot_pkg and score_ordered_table_top.
module score_ordered_table_top_tb;
  import sot_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 7;
  localparam int MAX_GAP = 16;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 2 * MAX_RESULTS + 8;
  localparam int HOLD_CYCLES = 300;
  localparam longint TIMEOUT = 64'd20_000_000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [SCORE_W-1:0]  score;
    logic                last;
  } table_beat_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [ID_W-1:0]     in_entry_id = '0;
  logic [SCORE_W-1:0]  in_entry_score = '0;
  logic [RC_W-1:0]     in_read_count = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_id;
  logic [SCORE_W-1:0]  out_score;
  logic                out_last;

  table_beat_t    pending_beats[$];
  table_beat_t    want_beat;
  logic [ID_W-1:0]    tbl_id[CAPACITY];
  logic [SCORE_W-1:0] tbl_score[CAPACITY];
  int unsigned    tbl_count = 0;
  int unsigned    error_count = 0;
  int unsigned    rx_wait = 0;
  bit             rx_hold = 1'b0;
  bit             tx_steady = 1'b0;
  bit             rx_steady = 1'b0;

  score_ordered_table_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_entry_id   (in_entry_id),
    .in_entry_score(in_entry_score),
    .in_read_count (in_read_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_id        (out_id),
    .out_score     (out_score),
    .out_last      (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, MAX_GAP);
    return 0;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 9);
    if (r == 6) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    return $urandom;
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 15);
    if (r == 4) return '0;
    if (r == 5) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(int unsigned ins_pct, int unsigned rem_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return FUNC_UNUSED;
    if (r < 3 + ins_pct) return FUNC_INSERT;
    if (r < 3 + ins_pct + rem_pct) return FUNC_REMOVE;
    return FUNC_READ;
  endfunction

  // Update the bench copy of the table and queue the beats this command causes.
  task automatic apply_command(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                               input logic [SCORE_W-1:0] sc, input logic [RC_W-1:0] rc);
    int unsigned pos;
    int unsigned wr;
    int unsigned n;
    int unsigned i;
    bit found;
    table_beat_t b;
    b = '0;
    b.last = 1'b1;
    case (f)
      FUNC_INSERT: begin
        if (tbl_count >= CAPACITY) begin
          b.status = STS_FULL;
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_score[pos] < sc) pos++;
          for (i = tbl_count; i > pos; i--) begin
            tbl_id[i] = tbl_id[i-1];
            tbl_score[i] = tbl_score[i-1];
          end
          tbl_id[pos] = id;
          tbl_score[pos] = sc;
          tbl_count++;
          b.status = STS_OK;
        end
        pending_beats = {pending_beats, b};
      end
      FUNC_REMOVE: begin
        wr = 0;
        found = 1'b0;
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_id[i] == id) begin
            found = 1'b1;
          end else begin
            tbl_id[wr] = tbl_id[i];
            tbl_score[wr] = tbl_score[i];
            wr++;
          end
        end
        tbl_count = wr;
        b.status = found ? STS_OK : STS_NOT_FOUND;
        pending_beats = {pending_beats, b};
      end
      FUNC_READ: begin
        n = 32'(rc);
        if (n > tbl_count) n = tbl_count;
        if (n > MAX_RESULTS) n = MAX_RESULTS;
        if (n == 0) begin
          b.status = STS_EMPTY;
          pending_beats = {pending_beats, b};
        end else begin
          for (i = 0; i < n; i++) begin
            b.status = STS_OK;
            b.id = tbl_id[i];
            b.score = tbl_score[i];
            b.last = (i + 1 == n);
            pending_beats = {pending_beats, b};
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] exp,
                                 input logic [31:0] act);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp, act);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      apply_command(in_func, in_entry_id, in_entry_score, in_read_count);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual status %0d id %h score %h last %b",
                 $time, out_status, out_id, out_score, out_last);
        error_count++;
      end else begin
        want_beat = pending_beats.pop_front();
        if (out_status !== want_beat.status)
          report_mismatch("status", want_beat.status, out_status);
        if (out_id !== want_beat.id) report_mismatch("out_id", want_beat.id, out_id);
        if (out_score !== want_beat.score)
          report_mismatch("out_score", want_beat.score, out_score);
        if (out_last !== want_beat.last) report_mismatch("out_last", want_beat.last, out_last);
      end
      rx_wait = rx_steady ? 0 : draw_gap();
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= (rx_wait > 0) || rx_hold;
  end

  // Offer one beat and return at the edge that accepts it.
  task automatic offer_command(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                               input logic [SCORE_W-1:0] sc, input logic [RC_W-1:0] rc);
    int unsigned gap;
    gap = tx_steady ? 0 : draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_entry_id <= id;
    in_entry_score <= sc;
    in_read_count <= rc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    offer_command(FUNC_READ, 32'd1, 32'd0, 6'd5);
    offer_command(FUNC_REMOVE, 32'd5, 32'd0, 6'd0);
    offer_command(FUNC_INSERT, 32'd0, 32'd0, 6'd0);
    offer_command(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    offer_command(FUNC_INSERT, 32'd7, 32'd100, 6'd0);
    offer_command(FUNC_INSERT, 32'd8, 32'd100, 6'd0);
    offer_command(FUNC_INSERT, 32'd7, 32'd50, 6'd0);
    offer_command(FUNC_READ, 32'd0, 32'd0, 6'd0);
    offer_command(FUNC_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd32);
    offer_command(FUNC_READ, 32'd0, 32'd0, 6'd1);
    offer_command(FUNC_UNUSED, 32'd7, 32'd3, 6'd32);
    offer_command(FUNC_REMOVE, 32'd7, 32'd0, 6'd0);
    offer_command(FUNC_READ, 32'd0, 32'd0, 6'd3);
    offer_command(FUNC_REMOVE, 32'd7, 32'd0, 6'd0);
    offer_command(FUNC_INSERT, 32'd0, 32'h8000_0000, 6'd0);
    offer_command(FUNC_REMOVE, 32'd0, 32'd0, 6'd0);
    offer_command(FUNC_REMOVE, 32'hFFFF_FFFF, 32'd0, 6'd0);
    offer_command(FUNC_REMOVE, 32'd8, 32'd0, 6'd0);
    offer_command(FUNC_READ, 32'd0, 32'd0, 6'd32);
    offer_command(FUNC_INSERT, 32'hA5A5_5A5A, 32'h0000_0100, 6'd0);
    offer_command(FUNC_READ, 32'd0, 32'd0, 6'd2);
    wait_until_drained();
  endtask

  task automatic test_fill_to_full();
    int unsigned n;
    n = CAPACITY - tbl_count + 3;
    repeat (n)
      offer_command(FUNC_INSERT, pick_id(), pick_score(), RC_W'($urandom_range(0, 32)));
    offer_command(FUNC_READ, $urandom, $urandom, 6'd32);
    offer_command(FUNC_READ, $urandom, $urandom, RC_W'($urandom_range(1, 31)));
    for (int k = 0; k < 10; k++)
      offer_command(FUNC_REMOVE, ID_W'(k), $urandom, RC_W'($urandom_range(0, 32)));
    offer_command(FUNC_READ, $urandom, $urandom, 6'd32);
    wait_until_drained();
  endtask

  task automatic run_mix_phase(input int unsigned count, input int unsigned ins_pct,
                               input int unsigned rem_pct);
    repeat (count)
      offer_command(pick_func(ins_pct, rem_pct), pick_id(), pick_score(),
                    RC_W'($urandom_range(0, 32)));
    wait_until_drained();
  endtask

  task automatic test_random_mix();
    run_mix_phase(65, 45, 22);
    tx_steady = 1'b1;
    run_mix_phase(65, 65, 10);
    tx_steady = 1'b0;
    rx_steady = 1'b1;
    run_mix_phase(65, 25, 40);
    tx_steady = 1'b1;
    run_mix_phase(30, 45, 22);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    run_mix_phase(35, 50, 20);
  endtask

  task automatic test_output_hold();
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (40) begin
      if ($urandom_range(0, 2) == 0)
        offer_command(FUNC_READ, pick_id(), pick_score(), 6'd32);
      else
        offer_command(pick_func(60, 15), pick_id(), pick_score(),
                      RC_W'($urandom_range(0, 32)));
    end
    wait_until_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_fill_to_full();
    test_random_mix();
    test_output_hold();
    test_fill_to_full();
    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_beats.size() == 0) begin
      $display("score_ordered_table_top test passed");
    end else begin
      if (pending_beats.size() != 0)
        $display("%0t: %0d expected beats never arrived", $time, pending_beats.size());
      $display("score_ordered_table_top test failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("%0t: timeout with %0d beats outstanding", $time, pending_beats.size());
    $display("score_ordered_table_top test failed");
    $finish;
  end

endmodule

@@ score_ordered_table_top.f @@
+incdir+rtl
rtl/sot_pkg.sv
rtl/sot_datapath.sv
rtl/sot_ctrl.sv
rtl/score_ordered_table_top.sv
test/score_ordered_table_top_tb.sv
